// ===== design/crov_pkg.sv =====
// shared types, constants and helpers of the cursor overlay highlight blend
// no dependencies; every other design file imports this package
package crov_pkg;

  localparam int unsigned HALF_W   = 12;
  localparam int unsigned RADIUS_W = 13;
  localparam int unsigned HOT_W    = 8;
  localparam int unsigned SIZE_W   = 9;
  localparam int unsigned BTN_W    = 3;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned POS_W    = 13;
  localparam int unsigned PIX_W    = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // queue between classifier and blender, power of two
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  localparam logic [PIX_W-1:0] HL_COLOR_B1 = 32'h8080_8000;
  localparam logic [PIX_W-1:0] HL_COLOR_B2 = 32'h8080_0080;
  localparam logic [PIX_W-1:0] HL_COLOR_B3 = 32'h8000_8080;
  localparam logic [7:0]       ALPHA_FULL  = 8'd255;

  localparam logic [HALF_W-1:0]   RST_HALF_SIZE = 12'd32;
  localparam logic [RADIUS_W-1:0] RST_RADIUS    = 13'd32;
  localparam logic [SIZE_W-1:0]   RST_SIDE      = 9'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_SIZE     = 3'd0,
    CFG_RADIUS        = 3'd1,
    CFG_HOT_X         = 3'd2,
    CFG_HOT_Y         = 3'd3,
    CFG_CURSOR_WIDTH  = 3'd4,
    CFG_CURSOR_HEIGHT = 3'd5,
    CFG_BUTTON_STATE  = 3'd6
  } crov_cfg_idx_t;

  typedef struct packed {
    logic [HALF_W-1:0]   half_size;
    logic [RADIUS_W-1:0] disc_radius;
    logic [HOT_W-1:0]    hot_x;
    logic [HOT_W-1:0]    hot_y;
    logic [SIZE_W-1:0]   cursor_width;
    logic [SIZE_W-1:0]   cursor_height;
    logic [BTN_W-1:0]    button_state;
  } crov_cfg_t;

  // one classified overlay pixel waiting for the blender
  typedef struct packed {
    logic [POS_W-1:0] tx;
    logic [POS_W-1:0] ty;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] bg;
    logic             blend;
  } crov_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } crov_q_ctl_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SQUARE,
    F_PUSH
  } crov_fstate_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_TRANS,
    B_ALPHA,
    B_NUM,
    B_DIV,
    B_OUT
  } crov_bstate_t;

  // x / 255 for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

// ===== design/crov_in_if.sv =====
// input channel of the cursor overlay blend: one argb cursor pixel per transaction
// depends on crov_pkg for widths
interface crov_in_if;
  import crov_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] cursor_pixel;

  modport source (output valid, output cursor_pixel, input ready);
  modport sink   (input valid, input cursor_pixel, output ready);
endinterface

// ===== design/crov_out_if.sv =====
// result channel of the cursor overlay blend: overlay position and composed colour
// depends on crov_pkg for widths
interface crov_out_if;
  import crov_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] target_x;
  logic [POS_W-1:0] target_y;
  logic [PIX_W-1:0] out_color;

  modport source (output valid, output target_x, output target_y, output out_color,
                  input ready);
  modport sink   (input valid, input target_x, input target_y, input out_color,
                  output ready);
endinterface

// ===== design/crov_front.sv =====
// classifier: raster counters, overlay placement, highlight disc test
// depends on crov_pkg and crov_in_if
module crov_front import crov_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  crov_cfg_t   cfg,
  crov_in_if.sink     in_ch,
  input  logic        q_full,
  output logic        q_push,
  output crov_entry_t q_entry
);

  crov_fstate_t state_r, state_nxt;
  logic [CNT_W-1:0] col_r, row_r;
  logic [PIX_W-1:0] pix_r;
  logic [POS_W-1:0] tx_r, ty_r;
  logic [7:0]       adx_r, ady_r;
  logic [15:0]      sqx_r, sqy_r;
  logic [25:0]      rsq_r;

  logic             accept;
  logic [13:0]      tx_w, ty_w;
  logic [POS_W-1:0] side_w;
  logic             in_overlay;
  logic [8:0]       dx_w, dy_w, ndx_w, ndy_w;
  logic [8:0]       col_p1, row_p1;
  logic [16:0]      dsq_w;
  logic             in_disc, hl_en;
  logic [PIX_W-1:0] hl_color;

  assign accept = in_ch.valid && in_ch.ready;

  // position in the overlay, may go negative from the hotspot shift
  assign tx_w   = {2'b00, cfg.half_size} + {6'd0, col_r} - {6'd0, cfg.hot_x};
  assign ty_w   = {2'b00, cfg.half_size} + {6'd0, row_r} - {6'd0, cfg.hot_y};
  assign side_w = {cfg.half_size, 1'b1};
  assign in_overlay = !tx_w[13] && !ty_w[13] && (tx_w[12:0] < side_w) &&
                      (ty_w[12:0] < side_w);

  assign dx_w  = {1'b0, col_r} - {1'b0, cfg.hot_x};
  assign dy_w  = {1'b0, row_r} - {1'b0, cfg.hot_y};
  assign ndx_w = 9'd0 - dx_w;
  assign ndy_w = 9'd0 - dy_w;

  assign col_p1 = {1'b0, col_r} + 9'd1;
  assign row_p1 = {1'b0, row_r} + 9'd1;

  assign dsq_w   = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign in_disc = {9'd0, dsq_w} < rsq_r;
  assign hl_en   = (cfg.disc_radius != '0) && (cfg.button_state != '0);

  always_comb begin
    if (!in_disc) begin
      hl_color = '0;
    end else if (cfg.button_state[0]) begin
      hl_color = HL_COLOR_B1;
    end else if (cfg.button_state[1]) begin
      hl_color = HL_COLOR_B2;
    end else begin
      hl_color = HL_COLOR_B3;
    end
  end

  assign q_entry.tx    = tx_r;
  assign q_entry.ty    = ty_r;
  assign q_entry.pix   = pix_r;
  assign q_entry.bg    = hl_color;
  assign q_entry.blend = hl_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (col_p1 >= cfg.cursor_width) begin
          col_r <= '0;
          row_r <= (row_p1 >= cfg.cursor_height) ? '0 : row_p1[CNT_W-1:0];
        end else begin
          col_r <= col_p1[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r <= in_ch.cursor_pixel;
      tx_r  <= tx_w[12:0];
      ty_r  <= ty_w[12:0];
      adx_r <= dx_w[8] ? ndx_w[7:0] : dx_w[7:0];
      ady_r <= dy_w[8] ? ndy_w[7:0] : dy_w[7:0];
    end
    if (state_r == F_SQUARE) begin
      sqx_r <= adx_r * adx_r;
      sqy_r <= ady_r * ady_r;
      rsq_r <= cfg.disc_radius * cfg.disc_radius;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    q_push      = 1'b0;
    case (state_r)
      F_IDLE: begin
        in_ch.ready = 1'b1;
        if (accept && in_overlay) begin
          state_nxt = F_SQUARE;
        end
      end
      F_SQUARE: begin
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  a_push_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> state_r == F_IDLE)
    else $error("classifier did not return to idle after a push");

endmodule

// ===== design/crov_fifo.sv =====
// short queue of classified pixels between classifier and blender
// depends on crov_pkg
module crov_fifo import crov_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  crov_entry_t wr_entry,
  input  logic        pop,
  output crov_entry_t rd_entry,
  output logic        full,
  output logic        empty
);

  crov_entry_t     mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r;

  assign full     = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign rd_entry = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from an empty queue");

endmodule

// ===== design/crov_back.sv =====
// blender: porter-duff over with a shared bit-serial divider, output register
// depends on crov_pkg and crov_out_if
module crov_back import crov_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  crov_entry_t q_entry,
  input  logic        q_empty,
  output logic        q_pop,
  crov_out_if.source  out_ch
);

  crov_bstate_t state_r, state_nxt;
  logic [POS_W-1:0] tx_r, ty_r;
  logic [PIX_W-1:0] src_r, bg_r;
  logic [PIX_W-1:0] color_r;
  logic [7:0]       t_r, a_r;
  logic [7:0]       rem_r, low_r;
  logic [1:0]       ch_r;
  logic [2:0]       bit_r;
  logic             out_valid_r;
  logic [POS_W-1:0] out_x_r, out_y_r;
  logic [PIX_W-1:0] out_color_r;

  logic [7:0]  sa, ba, src_ch, bg_ch;
  logic [4:0]  ch_off;
  logic [15:0] prod_t, num_w;
  logic [8:0]  a_w;
  logic [8:0]  trial;
  logic        qbit;
  logic        out_load;

  assign sa     = src_r[31:24];
  assign ba     = bg_r[31:24];
  assign ch_off = {ch_r, 3'b000};
  assign src_ch = src_r[ch_off +: 8];
  assign bg_ch  = bg_r[ch_off +: 8];
  assign prod_t = ba * (ALPHA_FULL - sa);
  assign a_w    = {1'b0, sa} + {1'b0, t_r};
  assign num_w  = (sa * src_ch) + (t_r * bg_ch);
  // remainder stays below a, so one more bit fits in nine
  assign trial  = {rem_r, low_r[7]};
  assign qbit   = trial >= {1'b0, a_r};

  assign out_load = (state_r == B_OUT) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.target_x  = out_x_r;
  assign out_ch.target_y  = out_y_r;
  assign out_ch.out_color = out_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        tx_r    <= q_entry.tx;
        ty_r    <= q_entry.ty;
        src_r   <= q_entry.pix;
        bg_r    <= q_entry.bg;
        color_r <= q_entry.pix;
      end
      B_TRANS: begin
        t_r <= div255(prod_t);
      end
      B_ALPHA: begin
        a_r     <= a_w[7:0];
        ch_r    <= 2'd0;
        color_r <= (a_w == '0) ? '0 : {a_w[7:0], 24'd0};
      end
      B_NUM: begin
        rem_r <= num_w[15:8];
        low_r <= num_w[7:0];
        bit_r <= 3'd0;
      end
      B_DIV: begin
        rem_r <= qbit ? 8'(trial - {1'b0, a_r}) : trial[7:0];
        low_r <= {low_r[6:0], qbit};
        bit_r <= bit_r + 3'd1;
        if (bit_r == 3'd7) begin
          color_r[ch_off +: 8] <= {low_r[6:0], qbit};
          ch_r                 <= ch_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_x_r     <= tx_r;
      out_y_r     <= ty_r;
      out_color_r <= color_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = q_entry.blend ? B_TRANS : B_OUT;
        end
      end
      B_TRANS: begin
        state_nxt = B_ALPHA;
      end
      B_ALPHA: begin
        state_nxt = (a_w == '0) ? B_OUT : B_NUM;
      end
      B_NUM: begin
        state_nxt = B_DIV;
      end
      B_DIV: begin
        if (bit_r == 3'd7) begin
          state_nxt = (ch_r == 2'd2) ? B_OUT : B_NUM;
        end
      end
      B_OUT: begin
        if (out_load) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_DIV |-> rem_r < a_r)
    else $error("divider remainder not below result alpha");

  a_alpha_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_ALPHA |=> state_r == B_NUM || state_r == B_OUT)
    else $error("unexpected state after alpha step");

endmodule

// ===== design/cursor_overlay_highlight_blend.sv =====
// cursor overlay highlight blend, top level: configuration registers and the
// classifier, queue and blender; depends on crov_pkg, crov_in_if, crov_out_if,
// crov_front, crov_fifo and crov_back
//
// Cursor pixels (ARGB, alpha in the top byte) enter in raster order on in_ch
// and are placed in a square overlay of side 2*half_size+1 with the hotspot on
// the centre; pixels outside the overlay give no transaction on out_ch, but
// still advance the column and row counters. With no button held, or with a
// zero radius, the pixel leaves unchanged; otherwise it is blended
// (unpremultiplied over, truncating) onto the highlight disc colour picked by
// button priority, or onto transparent outside the disc. The classifier accepts,
// squares and queue-pushes a pixel and takes no new one until the push; a pixel
// outside the overlay needs only the accept. The blender passes a pixel through
// by pop and output load, and blends one by pop, transparency, result alpha, a
// numerator step and 8 quotient bits of the single bit-serial divider per colour
// channel, and the output load; a blend whose result alpha is zero skips the
// divider. Output backpressure stalls the output load. A two-entry queue between
// classifier and blender and the output register let both sides stall on their
// own. Configuration is written through cfg_we/cfg_index/cfg_wdata by the user,
// only while the block is idle, which the block does not enforce; counters are
// not reset by a write, so a new image should start at an image boundary.

module cursor_overlay_highlight_blend import crov_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  crov_in_if.sink               in_ch,
  crov_out_if.source            out_ch
);

  crov_cfg_t   cfg_r;
  crov_entry_t push_entry, head_entry;
  crov_q_ctl_t q_ctl;

  // configuration registers, value bits above a register's width are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_size     <= RST_HALF_SIZE;
      cfg_r.disc_radius   <= RST_RADIUS;
      cfg_r.hot_x         <= '0;
      cfg_r.hot_y         <= '0;
      cfg_r.cursor_width  <= RST_SIDE;
      cfg_r.cursor_height <= RST_SIDE;
      cfg_r.button_state  <= '0;
    end else if (cfg_we) begin
      case (crov_cfg_idx_t'(cfg_index))
        CFG_HALF_SIZE:     cfg_r.half_size     <= cfg_wdata[HALF_W-1:0];
        CFG_RADIUS:        cfg_r.disc_radius   <= cfg_wdata[RADIUS_W-1:0];
        CFG_HOT_X:         cfg_r.hot_x         <= cfg_wdata[HOT_W-1:0];
        CFG_HOT_Y:         cfg_r.hot_y         <= cfg_wdata[HOT_W-1:0];
        CFG_CURSOR_WIDTH:  cfg_r.cursor_width  <= cfg_wdata[SIZE_W-1:0];
        CFG_CURSOR_HEIGHT: cfg_r.cursor_height <= cfg_wdata[SIZE_W-1:0];
        CFG_BUTTON_STATE:  cfg_r.button_state  <= cfg_wdata[BTN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front end: counters, overlay placement, disc test
  crov_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_ch   (in_ch),
    .q_full  (q_ctl.full),
    .q_push  (q_ctl.push),
    .q_entry (push_entry)
  );

  // decoupling queue
  crov_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_ctl.push),
    .wr_entry (push_entry),
    .pop      (q_ctl.pop),
    .rd_entry (head_entry),
    .full     (q_ctl.full),
    .empty    (q_ctl.empty)
  );

  // back end: over blend and result register
  crov_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_entry (head_entry),
    .q_empty (q_ctl.empty),
    .q_pop   (q_ctl.pop),
    .out_ch  (out_ch)
  );

endmodule
